[sv/rcfp_pkg.sv]
package rcfp_pkg;

  // Frame layout
  localparam int unsigned OVERHEAD       = 3;
  localparam int unsigned DEF_MAX_LENGTH = 32;
  localparam int unsigned DEF_CHANNELS   = 14;

  localparam logic [7:0]  CMD_CHANNELS = 8'h40;
  localparam logic [15:0] SUM_START    = 16'hFFFF;

  // Controller to datapath commands
  typedef struct packed {
    logic start_frame;
    logic take_data;
    logic take_low;
    logic chan_clear;
    logic rd_issue;
    logic load_out;
    logic next_chan;
  } rcfp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic len_ok;
    logic data_last;
    logic frame_ok;
    logic out_free;
    logic chan_last;
  } rcfp_sts_t;

endpackage

[sv/rc_channel_frame_parser.sv]
// Frame bytes are taken one per cycle while rx_stall_o is low.
// After the high checksum byte of a good channel frame the receive side stalls
// for every channel, and longer under output stall: one state (S_RD) for the
// two-port payload store read and one (S_WR) to load the output register.
// The first channel result is valid after the S_RD read and the S_WR load.
// Reset is asynchronous: parser returns to length hunting, payload store reads zero.
module rc_channel_frame_parser import rcfp_pkg::*; #(
  parameter int unsigned MAX_LENGTH = DEF_MAX_LENGTH,
  parameter int unsigned CHANNELS   = DEF_CHANNELS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  channel_index_o,
  output logic [15:0] channel_value_o,
  output logic        last_channel_o
);

  rcfp_cmd_t cmd;
  rcfp_sts_t sts;

  // Frame sequencing
  rcfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Checksum, payload store and channel output
  rcfp_datapath #(
    .MAX_LENGTH (MAX_LENGTH),
    .CHANNELS   (CHANNELS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_byte_i       (rx_byte_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .last_channel_o  (last_channel_o)
  );

endmodule

[sv/rcfp_ctrl.sv]
module rcfp_ctrl import rcfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      rx_valid_i,
  output logic      rx_stall_o,
  input  rcfp_sts_t sts_i,
  output rcfp_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_LEN  = 6'b000001,
    S_DATA = 6'b000010,
    S_CKL  = 6'b000100,
    S_CKH  = 6'b001000,
    S_RD   = 6'b010000,
    S_WR   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   rx_fire;

  // Hold the receive side while channels are read out
  assign rx_stall_o = (state_q == S_RD) || (state_q == S_WR);
  assign rx_fire    = rx_valid_i && !rx_stall_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_LEN: begin
        if (rx_fire && sts_i.len_ok) begin
          cmd_o.start_frame = 1'b1;
          state_d           = S_DATA;
        end
      end
      S_DATA: begin
        if (rx_fire) begin
          cmd_o.take_data = 1'b1;
          if (sts_i.data_last) state_d = S_CKL;
        end
      end
      S_CKL: begin
        if (rx_fire) begin
          cmd_o.take_low = 1'b1;
          state_d        = S_CKH;
        end
      end
      S_CKH: begin
        if (rx_fire) begin
          if (sts_i.frame_ok) begin
            cmd_o.chan_clear = 1'b1;
            state_d          = S_RD;
          end else begin
            state_d = S_LEN;
          end
        end
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_WR;
      end
      S_WR: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (sts_i.chan_last) begin
            state_d = S_LEN;
          end else begin
            cmd_o.next_chan = 1'b1;
            state_d         = S_RD;
          end
        end
      end
      default: state_d = S_LEN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LEN;
    end else begin
      state_q <= state_d;
    end
  end

  // Exactly one state is active
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state not one-hot");

  // A good frame always starts the readout
  a_good_frame_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CKH) && rx_fire && sts_i.frame_ok |=> (state_q == S_RD))
    else $error("good frame did not start channel readout");

  // The last channel returns to length hunting
  a_last_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out && sts_i.chan_last |=> (state_q == S_LEN))
    else $error("controller did not return after last channel");

endmodule

[sv/rcfp_datapath.sv]
module rcfp_datapath import rcfp_pkg::*; #(
  parameter int unsigned MAX_LENGTH = DEF_MAX_LENGTH,
  parameter int unsigned CHANNELS   = DEF_CHANNELS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  rx_byte_i,
  input  rcfp_cmd_t   cmd_i,
  output rcfp_sts_t   sts_o,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [3:0]  channel_index_o,
  output logic [15:0] channel_value_o,
  output logic        last_channel_o
);

  localparam int unsigned Depth = MAX_LENGTH - OVERHEAD;
  localparam int unsigned Aw    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned Cw    = $clog2(MAX_LENGTH);
  localparam int unsigned Kw    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned Xw    = $clog2(2 * CHANNELS + Depth + 1);

  // Frame state
  logic [Cw-1:0] ptr_q, len_q;
  logic [15:0]   sum_q;
  logic [7:0]    low_q;
  logic [7:0]    cmd_byte_q;

  // Payload store with per-entry valid bits
  logic [7:0]       store_mem [Depth];
  logic [Depth-1:0] valid_q;
  logic             wr_en;

  // Readout
  logic [Kw-1:0] chan_q;
  logic [Xw-1:0] addr_lo, addr_hi;
  logic          lo_in, hi_in;
  logic [Aw-1:0] idx_lo, idx_hi;
  logic [7:0]    rd_lo_q, rd_hi_q;
  logic          lo_ok_q, hi_ok_q;

  // Output register
  logic        out_valid_q;
  logic [3:0]  out_index_q;
  logic [15:0] out_value_q;
  logic        out_last_q;

  // Status to the controller
  assign sts_o.len_ok    = (rx_byte_i > 8'(OVERHEAD)) && (rx_byte_i <= 8'(MAX_LENGTH));
  assign sts_o.data_last = ({1'b0, ptr_q} + 1'b1) >= {1'b0, len_q};
  assign sts_o.frame_ok  = (sum_q == {rx_byte_i, low_q}) && (cmd_byte_q == CMD_CHANNELS);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.chan_last = (chan_q == Kw'(CHANNELS - 1));

  // Track frame length, pointer and checksum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      len_q <= '0;
      sum_q <= '0;
      low_q <= '0;
    end else begin
      if (cmd_i.start_frame) begin
        ptr_q <= '0;
        len_q <= Cw'(rx_byte_i - 8'(OVERHEAD));
        sum_q <= SUM_START - {8'h00, rx_byte_i};
      end
      if (cmd_i.take_data) begin
        ptr_q <= ptr_q + 1'b1;
        sum_q <= sum_q - {8'h00, rx_byte_i};
      end
      if (cmd_i.take_low) low_q <= rx_byte_i;
    end
  end

  // Capture the command byte at payload position zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_data && (ptr_q == '0)) cmd_byte_q <= rx_byte_i;
  end

  // Write payload bytes that fit the store
  assign wr_en = cmd_i.take_data && (ptr_q < Cw'(Depth));

  always_ff @(posedge clk_i) begin
    if (wr_en) store_mem[ptr_q[Aw-1:0]] <= rx_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[ptr_q[Aw-1:0]] <= 1'b1;
    end
  end

  // Channel counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= '0;
    end else if (cmd_i.chan_clear) begin
      chan_q <= '0;
    end else if (cmd_i.next_chan) begin
      chan_q <= chan_q + 1'b1;
    end
  end

  // Byte addresses of the current channel
  assign addr_lo = Xw'({chan_q, 1'b0}) + Xw'(1);
  assign addr_hi = Xw'({chan_q, 1'b0}) + Xw'(2);
  assign lo_in   = addr_lo < Xw'(Depth);
  assign hi_in   = addr_hi < Xw'(Depth);
  assign idx_lo  = lo_in ? addr_lo[Aw-1:0] : '0;
  assign idx_hi  = hi_in ? addr_hi[Aw-1:0] : '0;

  // Registered two-port read; unwritten or out-of-range bytes read as zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rd_lo_q <= store_mem[idx_lo];
      rd_hi_q <= store_mem[idx_hi];
      lo_ok_q <= lo_in && valid_q[idx_lo];
      hi_ok_q <= hi_in && valid_q[idx_hi];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_index_q <= 4'(chan_q);
      out_value_q <= {(hi_ok_q ? rd_hi_q : 8'h00), (lo_ok_q ? rd_lo_q : 8'h00)};
      out_last_q  <= sts_o.chan_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign channel_index_o = out_index_q;
  assign channel_value_o = out_value_q;
  assign last_channel_o  = out_last_q;

  // Never overwrite a pending transaction
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while stalled");

  // Payload bytes stay within the announced length
  a_ptr_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_data |-> (ptr_q < len_q))
    else $error("payload byte beyond frame length");

  // The final channel carries the last flag
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out && sts_o.chan_last |=> out_valid_q && out_last_q)
    else $error("last channel not flagged");

endmodule
